// File: hdl/vts_pkg.sv
// ----------------------------------------------------------------------------
// vts_pkg: shared types and constants for the value table search unit
// Table depth, field widths, action codes and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none
package vts_pkg;
   localparam int DEPTH       = 8;
   localparam int VALUE_WIDTH = 16;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);

   localparam logic [2:0] ACT_APPEND = 3'd0;
   localparam logic [2:0] ACT_FIND   = 3'd1;
   localparam logic [2:0] ACT_RANGE  = 3'd2;
   localparam logic [2:0] ACT_ALL    = 3'd3;
   localparam logic [2:0] ACT_REMOVE = 3'd4;
   localparam logic [2:0] ACT_DEDUP  = 3'd5;
   localparam logic [2:0] ACT_READ   = 3'd6;
   localparam logic [2:0] ACT_CLEAR  = 3'd7;

   typedef struct packed {
      logic load;      // capture request
      logic rd_start;  // read entry rd_addr (scan or dedup outer index)
      logic [IDX_W-1:0] rd_addr;
      logic wr;        // write entry wr_addr with data chosen by wr_from_rd
      logic [IDX_W-1:0] wr_addr;
      logic wr_from_rd; // 1: last read data, 0: request value
      logic set_key;   // key <= last read data
   } vts_cmd_type;

   typedef struct packed {
      logic             eq;    // last read == key
      logic             in_rng;
   } vts_sts_type;
endpackage
`default_nettype wire

// File: hdl/value_table_search_and_compaction_unit.sv
// A scan reads and then evaluates each entry in turn; find all scans the
// table a second time when the first pass found a match, and dedup rescans
// the entries after each outer entry against its value.
// Throughput: one action at a time; a result still waiting in the output
// register holds the sequencer, and the next request is taken once idle.
// Reset: synchronous, active high; empties the table, entries keep old bits.
// ----------------------------------------------------------------------------
// value_table_search_and_compaction_unit: value table with search/compaction
// Controller sequences scans; datapath holds entries and comparators.
// ----------------------------------------------------------------------------
`default_nettype none
module value_table_search_and_compaction_unit
   import vts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_action,
   input  wire logic [15:0] req_value,
   input  wire logic [15:0] req_range_top,
   input  wire logic [5:0]  req_entry_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_found,
   output logic [5:0]       rsp_position,
   output logic [6:0]       rsp_tally,
   output logic [6:0]       rsp_table_length,
   output logic [15:0]      rsp_read_value,
   output logic             rsp_is_last,
   output logic             rsp_fault
);
   vts_cmd_type cmd;
   vts_sts_type sts;
   logic [VALUE_WIDTH-1:0] rd_data;

   vts_datapath u_dp (
      .clock, .cmd, .req_value, .req_range_top, .sts, .rd_data
   );

   vts_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_entry_index,
      .cmd, .sts, .rd_data, .rsp_valid, .rsp_stall, .rsp_found, .rsp_position,
      .rsp_tally, .rsp_table_length, .rsp_read_value, .rsp_is_last, .rsp_fault
   );
endmodule
`default_nettype wire

// File: hdl/vts_datapath.sv
// ----------------------------------------------------------------------------
// vts_datapath: entry memory, request registers and comparators
// Single-port style table; read data registered, compared against a key and a value range.
// ----------------------------------------------------------------------------
`default_nettype none
module vts_datapath
   import vts_pkg::*;
(
   input  wire logic                   clock,
   input  wire vts_cmd_type            cmd,
   input  wire logic [15:0]            req_value,
   input  wire logic [15:0]            req_range_top,
   output vts_sts_type                 sts,
   output logic [VALUE_WIDTH-1:0]      rd_data
);
   logic [VALUE_WIDTH-1:0] mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_ff;
   logic [VALUE_WIDTH-1:0] val_ff, val_in, top_ff, top_in, key_ff, key_in;

   always_comb begin
      val_in = val_ff;
      top_in = top_ff;
      key_in = key_ff;
      if (cmd.load) begin
         val_in = VALUE_WIDTH'(req_value);
         top_in = VALUE_WIDTH'(req_range_top);
         key_in = VALUE_WIDTH'(req_value);
      end else if (cmd.set_key) begin
         key_in = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      top_ff <= top_in;
      key_ff <= key_in;
      if (cmd.rd_start) rd_ff <= mem[cmd.rd_addr];
      if (cmd.wr) mem[cmd.wr_addr] <= cmd.wr_from_rd ? rd_ff : val_ff;
   end

   assign sts.eq     = (rd_ff == key_ff);
   assign sts.in_rng = (rd_ff >= val_ff) && (rd_ff <= top_ff);
   assign rd_data    = rd_ff;
endmodule
`default_nettype wire

// File: hdl/vts_control.sv
// ----------------------------------------------------------------------------
// vts_control: sequencer for all table actions
// Scans the table one entry at a time (read, then evaluate) and
// compacts in place with a separate write pointer.
// ----------------------------------------------------------------------------
`default_nettype none
module vts_control
   import vts_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_action,
   input  wire logic [5:0]         req_entry_index,
   output vts_cmd_type             cmd,
   input  wire vts_sts_type        sts,
   input  wire logic [VALUE_WIDTH-1:0] rd_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_found,
   output logic [5:0]              rsp_position,
   output logic [6:0]              rsp_tally,
   output logic [6:0]              rsp_table_length,
   output logic [15:0]             rsp_read_value,
   output logic                    rsp_is_last,
   output logic                    rsp_fault
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1; // issue read at scan (or dedup outer) index
   localparam logic [2:0] S_EV   = 3'd2; // evaluate read data
   localparam logic [2:0] S_OUT  = 3'd3; // hold result until the result register is free or transferring
   localparam logic [2:0] S_OREQ = 3'd4; // find-all emit pass
   localparam logic [2:0] S_RDR  = 3'd5; // read action: issue read at entry index

   logic [2:0] st_ff, st_in;
   logic [2:0] act_ff, act_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] i_ff, i_in;   // scan index
   logic [CNT_W-1:0] w_ff, w_in;   // write pointer (remove and dedup compaction)
   logic [CNT_W-1:0] o_ff, o_in;   // dedup outer index
   logic [CNT_W-1:0] n_ff, n_in;   // match / removed count
   logic [CNT_W-1:0] k_ff, k_in;   // find-all emitted count
   logic pass2_ff, pass2_in;       // find-all second pass / dedup key phase

   logic v_ff, v_in, fd_ff, fd_in, last_ff, last_in, flt_ff, flt_in;
   logic [5:0] pos_ff, pos_in;
   logic [6:0] tal_ff, tal_in;
   logic [15:0] rv_ff, rv_in;

   logic done_o;
   assign done_o = rsp_stall == 1'b0;

   always_comb begin
      st_in = st_ff; act_in = act_ff; len_in = len_ff; i_in = i_ff; w_in = w_ff;
      o_in = o_ff; n_in = n_ff; k_in = k_ff; pass2_in = pass2_ff;
      v_in = v_ff; fd_in = fd_ff; last_in = last_ff; flt_in = flt_ff;
      pos_in = pos_ff; tal_in = tal_ff; rv_in = rv_ff;
      cmd = '0;
      cmd.rd_addr = i_ff[IDX_W-1:0];
      cmd.wr_addr = w_ff[IDX_W-1:0];
      if (v_ff && done_o) v_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               act_in = req_action;
               i_in = '0; w_in = '0; o_in = '0; n_in = '0; k_in = '0;
               pass2_in = 1'b0;
               fd_in = 1'b0; pos_in = '0; tal_in = '0; rv_in = '0;
               flt_in = 1'b0; last_in = 1'b1;
               unique case (req_action)
                  ACT_APPEND: st_in = S_EV;
                  ACT_CLEAR: begin
                     len_in = '0; st_in = S_OUT;
                  end
                  ACT_READ: begin
                     if ({1'b0, req_entry_index} < 7'(len_ff)) begin
                        i_in = CNT_W'(req_entry_index); st_in = S_RDR;
                     end else begin
                        flt_in = 1'b1; st_in = S_OUT;
                     end
                  end
                  ACT_DEDUP: begin
                     pass2_in = 1'b1; st_in = S_RD; // key phase first
                  end
                  default: st_in = S_RD;
               endcase
            end
         end
         S_RDR: begin
            cmd.rd_start = 1'b1;
            st_in = S_EV;
         end
         S_RD: begin
            priority if (act_ff == ACT_DEDUP && pass2_ff) begin
               if (o_ff >= len_ff) begin
                  tal_in = 7'(n_ff); st_in = S_OUT;
               end else begin
                  cmd.rd_addr = o_ff[IDX_W-1:0];
                  cmd.rd_start = 1'b1; st_in = S_EV;
               end
            end else if (i_ff >= len_ff) begin
               // scan finished
               unique case (act_ff)
                  ACT_FIND: st_in = S_OUT;
                  ACT_RANGE: begin
                     tal_in = 7'(n_ff); fd_in = n_ff != '0; st_in = S_OUT;
                  end
                  ACT_ALL: begin
                     if (pass2_ff || n_ff == '0) st_in = S_OUT;
                     else begin
                        pass2_in = 1'b1; i_in = '0;
                     end
                  end
                  ACT_REMOVE: begin
                     len_in = w_ff; tal_in = 7'(n_ff); fd_in = n_ff != '0;
                     st_in = S_OUT;
                  end
                  default: begin // dedup inner done
                     len_in = w_ff; o_in = o_ff + 1'b1; pass2_in = 1'b1;
                  end
               endcase
            end else begin
               cmd.rd_start = 1'b1; st_in = S_EV;
            end
         end
         S_EV: begin
            unique case (act_ff)
               ACT_APPEND: begin
                  if (len_ff >= CNT_W'(DEPTH)) flt_in = 1'b1;
                  else begin
                     cmd.wr = 1'b1; cmd.wr_addr = len_ff[IDX_W-1:0];
                     len_in = len_ff + 1'b1;
                  end
                  st_in = S_OUT;
               end
               ACT_READ: begin
                  rv_in = 16'(rd_data); st_in = S_OUT;
               end
               ACT_FIND: begin
                  if (sts.eq) begin
                     fd_in = 1'b1; pos_in = 6'(i_ff); st_in = S_OUT;
                  end else begin
                     i_in = i_ff + 1'b1; st_in = S_RD;
                  end
               end
               ACT_RANGE: begin
                  if (sts.in_rng) n_in = n_ff + 1'b1;
                  i_in = i_ff + 1'b1; st_in = S_RD;
               end
               ACT_ALL: begin
                  i_in = i_ff + 1'b1; st_in = S_RD;
                  if (sts.eq) begin
                     if (!pass2_ff) n_in = n_ff + 1'b1;
                     else begin
                        fd_in = 1'b1; pos_in = 6'(i_ff); tal_in = 7'(n_ff);
                        k_in = k_ff + 1'b1;
                        last_in = (k_ff + 1'b1) == n_ff;
                        st_in = S_OREQ;
                     end
                  end
               end
               ACT_REMOVE: begin
                  if (sts.eq) n_in = n_ff + 1'b1;
                  else begin
                     cmd.wr = 1'b1; cmd.wr_from_rd = 1'b1;
                     w_in = w_ff + 1'b1;
                  end
                  i_in = i_ff + 1'b1; st_in = S_RD;
               end
               default: begin // dedup
                  if (pass2_ff) begin
                     // key loaded from entry o; compact entries after it
                     cmd.set_key = 1'b1; pass2_in = 1'b0;
                     i_in = o_ff + 1'b1; w_in = o_ff + 1'b1;
                  end else begin
                     if (sts.eq) n_in = n_ff + 1'b1;
                     else begin
                        cmd.wr = 1'b1; cmd.wr_from_rd = 1'b1;
                        w_in = w_ff + 1'b1;
                     end
                     i_in = i_ff + 1'b1;
                  end
                  st_in = S_RD;
               end
            endcase
         end
         S_OREQ: begin
            if (!v_ff || done_o) begin
               v_in = 1'b1;
               st_in = last_ff ? S_IDLE : S_RD;
            end
         end
         default: begin // S_OUT
            if (!v_ff || done_o) begin
               v_in = 1'b1; last_in = 1'b1; st_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; len_ff <= '0; v_ff <= 1'b0;
      end else begin
         st_ff <= st_in; len_ff <= len_in; v_ff <= v_in;
      end
      act_ff <= act_in; i_ff <= i_in; w_ff <= w_in; o_ff <= o_in; n_ff <= n_in;
      k_ff <= k_in; pass2_ff <= pass2_in;
      fd_ff <= fd_in; last_ff <= last_in; flt_ff <= flt_in;
      pos_ff <= pos_in; tal_ff <= tal_in; rv_ff <= rv_in;
   end

   // result register, loaded only when free or being transferred
   logic ofd_ff, olast_ff, oflt_ff;
   logic [5:0] opos_ff;
   logic [6:0] otal_ff, olen_ff;
   logic [15:0] orv_ff;
   always_ff @(posedge clock) begin
      if ((st_ff == S_OUT || st_ff == S_OREQ) && (!v_ff || done_o)) begin
         ofd_ff <= fd_ff; olast_ff <= last_ff; oflt_ff <= flt_ff;
         opos_ff <= pos_ff; otal_ff <= tal_ff; olen_ff <= 7'(len_ff);
         orv_ff <= rv_ff;
      end
   end

   assign req_stall        = st_ff != S_IDLE;
   assign rsp_valid        = v_ff;
   assign rsp_found        = ofd_ff;
   assign rsp_position     = opos_ff;
   assign rsp_tally        = otal_ff;
   assign rsp_table_length = olen_ff;
   assign rsp_read_value   = orv_ff;
   assign rsp_is_last      = olast_ff;
   assign rsp_fault        = oflt_ff;
endmodule
`default_nettype wire

// File: tb/tb_value_table_search_and_compaction_unit.sv
// ----------------------------------------------------------------------------
// tb_value_table_search_and_compaction_unit: self-checking bench for the table
// Drives directed and random table actions through the request channel,
// predicts every response from a local table model and checks each transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_value_table_search_and_compaction_unit;
   import vts_pkg::*;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] value;
      logic [15:0] range_top;
      logic [5:0]  entry_index;
      logic        wait_drain;
   } table_op_type;

   typedef struct packed {
      logic        found;
      logic [5:0]  position;
      logic [6:0]  tally;
      logic [6:0]  table_length;
      logic [15:0] read_value;
      logic        is_last;
      logic        fault;
   } table_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = ACT_CLEAR;
   logic [15:0] req_value = '0;
   logic [15:0] req_range_top = '0;
   logic [5:0]  req_entry_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic [5:0]  rsp_position;
   logic [6:0]  rsp_tally;
   logic [6:0]  rsp_table_length;
   logic [15:0] rsp_read_value;
   logic        rsp_is_last;
   logic        rsp_fault;

   value_table_search_and_compaction_unit uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   table_op_type  pending_ops[$];
   table_rsp_type expected_rsps[$];
   logic [15:0] shadow_table[DEPTH];
   int unsigned shadow_fill = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   bit stimulus_done = 1'b0;
   bit req_taken = 1'b0;
   int burst_left = 0;
   int gap_left = 0;

   function automatic table_rsp_type make_rsp(logic found, int pos, int tally,
                                              int rd, logic last, logic fault);
      table_rsp_type r;
      r.found = found;
      r.position = pos[5:0];
      r.tally = tally[6:0];
      r.table_length = shadow_fill[6:0];
      r.read_value = rd[15:0];
      r.is_last = last;
      r.fault = fault;
      return r;
   endfunction

   task automatic drop_entry(int unsigned at);
      for (int unsigned j = at; j + 1 < shadow_fill; j++)
         shadow_table[j] = shadow_table[j + 1];
      shadow_fill--;
   endtask

   // Apply one accepted action to the shadow table and queue its responses.
   task automatic predict_action(table_op_type op);
      int n;
      int k;
      int unsigned i;
      int unsigned j;
      n = 0;
      case (op.action)
         ACT_APPEND: begin
            if (shadow_fill >= DEPTH) begin
               expected_rsps.push_back(make_rsp(0, 0, 0, 0, 1, 1));
            end else begin
               shadow_table[shadow_fill] = op.value;
               shadow_fill++;
               expected_rsps.push_back(make_rsp(0, 0, 0, 0, 1, 0));
            end
         end
         ACT_FIND: begin
            k = -1;
            for (i = 0; i < shadow_fill; i++)
               if (k < 0 && shadow_table[i] == op.value) k = i;
            if (k >= 0) expected_rsps.push_back(make_rsp(1, k, 0, 0, 1, 0));
            else expected_rsps.push_back(make_rsp(0, 0, 0, 0, 1, 0));
         end
         ACT_RANGE: begin
            for (i = 0; i < shadow_fill; i++)
               if (shadow_table[i] >= op.value && shadow_table[i] <= op.range_top) n++;
            expected_rsps.push_back(make_rsp(n != 0, 0, n, 0, 1, 0));
         end
         ACT_ALL: begin
            for (i = 0; i < shadow_fill; i++)
               if (shadow_table[i] == op.value) n++;
            if (n == 0) begin
               expected_rsps.push_back(make_rsp(0, 0, 0, 0, 1, 0));
            end else begin
               k = 0;
               for (i = 0; i < shadow_fill; i++)
                  if (shadow_table[i] == op.value) begin
                     k++;
                     expected_rsps.push_back(make_rsp(1, i, n, 0, k == n, 0));
                  end
            end
         end
         ACT_REMOVE: begin
            i = 0;
            while (i < shadow_fill) begin
               if (shadow_table[i] == op.value) begin
                  drop_entry(i);
                  n++;
               end else begin
                  i++;
               end
            end
            expected_rsps.push_back(make_rsp(n != 0, 0, n, 0, 1, 0));
         end
         ACT_DEDUP: begin
            for (i = 0; i < shadow_fill; i++) begin
               j = i + 1;
               while (j < shadow_fill) begin
                  if (shadow_table[j] == shadow_table[i]) begin
                     drop_entry(j);
                     n++;
                  end else begin
                     j++;
                  end
               end
            end
            expected_rsps.push_back(make_rsp(0, 0, n, 0, 1, 0));
         end
         ACT_READ: begin
            if (op.entry_index < shadow_fill)
               expected_rsps.push_back(make_rsp(0, 0, 0,
                                                shadow_table[op.entry_index], 1, 0));
            else
               expected_rsps.push_back(make_rsp(0, 0, 0, 0, 1, 1));
         end
         default: begin
            shadow_fill = 0;
            expected_rsps.push_back(make_rsp(0, 0, 0, 0, 1, 0));
         end
      endcase
   endtask

   logic [15:0] recent_values[$];

   task automatic queue_op(logic [2:0] act, logic [15:0] val, logic [15:0] top,
                           logic [5:0] idx, logic drain = 1'b0);
      table_op_type op;
      op.action = act;
      op.value = val;
      op.range_top = top;
      op.entry_index = idx;
      op.wait_drain = drain;
      pending_ops.push_back(op);
      if (act == ACT_APPEND) begin
         if (recent_values.size() > 6) void'(recent_values.pop_front());
         recent_values.push_back(val);
      end
   endtask

   function automatic logic [15:0] pick_value();
      if (recent_values.size() != 0 && $urandom_range(0, 3) != 0)
         return recent_values[$urandom_range(0, recent_values.size() - 1)];
      if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 3));
      return 16'($urandom);
   endfunction

   initial begin
      logic [2:0] act;
      logic [15:0] v;
      logic [15:0] w;
      // Directed: extremes, full table, every action and each special case.
      queue_op(ACT_READ, 16'h0, 16'h0, 6'd0);
      queue_op(ACT_FIND, 16'h1234, 16'h0, 6'd0);
      queue_op(ACT_ALL, 16'h1234, 16'h0, 6'd0);
      queue_op(ACT_APPEND, 16'h0000, 16'h0, 6'd0);
      queue_op(ACT_APPEND, 16'hFFFF, 16'hFFFF, 6'd63);
      queue_op(ACT_APPEND, 16'h0000, 16'h0, 6'd0);
      queue_op(ACT_APPEND, 16'hA5A5, 16'h0, 6'd0);
      queue_op(ACT_APPEND, 16'hFFFF, 16'h0, 6'd0);
      queue_op(ACT_APPEND, 16'h5A5A, 16'h0, 6'd0);
      queue_op(ACT_APPEND, 16'h0000, 16'h0, 6'd0);
      queue_op(ACT_APPEND, 16'h7FFF, 16'h0, 6'd0);
      queue_op(ACT_APPEND, 16'h1111, 16'h0, 6'd0);
      queue_op(ACT_READ, 16'h0, 16'h0, 6'd7);
      queue_op(ACT_READ, 16'h0, 16'h0, 6'd63);
      queue_op(ACT_FIND, 16'hFFFF, 16'h0, 6'd0);
      queue_op(ACT_ALL, 16'h0000, 16'h0, 6'd0);
      queue_op(ACT_RANGE, 16'h0000, 16'hFFFF, 6'd0);
      queue_op(ACT_RANGE, 16'hFFFF, 16'h0000, 6'd0);
      queue_op(ACT_RANGE, 16'hA5A5, 16'hA5A5, 6'd0);
      queue_op(ACT_REMOVE, 16'h4242, 16'h0, 6'd0);
      queue_op(ACT_DEDUP, 16'h0, 16'h0, 6'd0);
      queue_op(ACT_REMOVE, 16'hFFFF, 16'h0, 6'd0, 1'b1);
      queue_op(ACT_READ, 16'h0, 16'h0, 6'd2);
      queue_op(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 6'd63);
      queue_op(ACT_READ, 16'h0, 16'h0, 6'd0);
      // Random: action mix biased toward append, mostly reusing recent values.
      for (int n = 0; n < 385; n++) begin
         act = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 9) < 3) act = ACT_APPEND;
         if (act == ACT_CLEAR && $urandom_range(0, 2) != 0) act = ACT_APPEND;
         v = pick_value();
         w = ($urandom_range(0, 4) == 0) ? 16'(~$urandom_range(0, 3)) : 16'($urandom);
         if (act == ACT_RANGE && $urandom_range(0, 1) == 0 && v > w) begin
            logic [15:0] t;
            t = v;
            v = w;
            w = t;
         end
         queue_op(act, v, w, 6'($urandom_range(0, 63)), n == 200);
      end
      stimulus_done = 1'b1;
   end

   table_op_type cur_op;

   always @(negedge clock) begin
      if (!reset) begin
         // hold the payload until the pending transfer happens
         if (!req_valid || req_taken) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].wait_drain && expected_rsps.size() != 0)) begin
               cur_op = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_action <= cur_op.action;
               req_value <= cur_op.value;
               req_range_top <= cur_op.range_top;
               req_entry_index <= cur_op.entry_index;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= (cycle_count % 300 < 100) ? 1'b0 : ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      table_rsp_type got;
      table_rsp_type want;
      cycle_count <= cycle_count + 1;
      req_taken = 1'b0;
      if (!reset) begin
         req_taken = req_valid && !req_stall;
         if (req_taken)
            predict_action('{req_action, req_value, req_range_top, req_entry_index, 1'b0});
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_found, rsp_position, rsp_tally, rsp_table_length,
                    rsp_read_value, rsp_is_last, rsp_fault};
            if (expected_rsps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response transfer: %p", got);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %p, actual %p", want, got);
               end
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && pending_ops.size() == 0);
      @(negedge clock);
      while (req_valid || expected_rsps.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      wait (cycle_count >= 400000);
      $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire

// File: value_table_search_and_compaction_unit.f
hdl/vts_pkg.sv
hdl/vts_datapath.sv
hdl/vts_control.sv
hdl/value_table_search_and_compaction_unit.sv
tb/tb_value_table_search_and_compaction_unit.sv
